[src/gain_matrix_mixer_with_lfe_defines.svh]
// Assertion helpers for the mixer sources (included by gmm_back).
`ifndef GAIN_MATRIX_MIXER_WITH_LFE_DEFINES_SVH
`define GAIN_MATRIX_MIXER_WITH_LFE_DEFINES_SVH

// Checked on every edge outside reset.
`define GMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define GMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/gmm_pkg.sv]
package gmm_pkg;

  localparam int unsigned MAX_MATRIX_IN_DEF  = 16;
  localparam int unsigned MAX_MATRIX_OUT_DEF = 16;
  localparam int unsigned MAX_HOST_OUT_DEF   = 32;
  localparam int unsigned SAMPLE_BITS_DEF    = 24;
  localparam int unsigned GAIN_BITS_DEF      = 20;

  localparam int unsigned ACC_BITS    = 48;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned CHAN_W      = 5;
  localparam int unsigned COEF_IDX_W  = 4;
  // wide enough for any channel times matrix output count plus an index
  localparam int unsigned ADDR_CALC_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_INPUTS  = 3'd0,
    REG_MATRIX_OUTPUTS = 3'd1,
    REG_LFE_IN_INDEX   = 3'd2,
    REG_LFE_OUT_INDEX  = 3'd3,
    REG_HOST_INPUTS    = 3'd4,
    REG_HOST_OUTPUTS   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_COEF,
    OP_MAC
  } op_e;

  typedef struct packed {
    op_e  op;
    logic frame_end;
  } ctrl_t;

  typedef struct packed {
    logic        [4:0] matrix_inputs;
    logic        [4:0] matrix_outputs;
    logic signed [5:0] lfe_in_index;
    logic signed [5:0] lfe_out_index;
    logic        [4:0] host_inputs;
    logic        [5:0] host_outputs;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  // channel sits on the LFE slot (negative index: no LFE)
  function automatic logic lfe_hit(logic [5:0] chan, logic signed [5:0] lfe);
    return !lfe[5] && (chan == $unsigned(lfe));
  endfunction

  // channel lies above the LFE slot and moves by one
  function automatic logic lfe_past(logic [5:0] chan, logic signed [5:0] lfe);
    return !lfe[5] && (chan > $unsigned(lfe));
  endfunction

endpackage

[src/gmm_ram.sv]
module gmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/gmm_queue.sv]
module gmm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/gmm_front.sv]
module gmm_front #(
  parameter int unsigned MAX_MATRIX_IN  = gmm_pkg::MAX_MATRIX_IN_DEF,
  parameter int unsigned MAX_MATRIX_OUT = gmm_pkg::MAX_MATRIX_OUT_DEF,
  parameter int unsigned SAMPLE_BITS    = gmm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_BITS      = gmm_pkg::GAIN_BITS_DEF,
  localparam int unsigned GA_DEPTH = MAX_MATRIX_IN * MAX_MATRIX_OUT,
  localparam int unsigned GA_W     = (GA_DEPTH > 1) ? $clog2(GA_DEPTH) : 1,
  localparam int unsigned DW       = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS
) (
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  mode_i,
  input  logic [gmm_pkg::CHAN_W-1:0]            channel_i,
  input  logic [gmm_pkg::COEF_IDX_W-1:0]        coef_out_index_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in_i,
  input  logic signed [GAIN_BITS-1:0]           gain_value_i,
  input  logic                                  frame_end_i,
  input  gmm_pkg::cfg_t                         cfg_i,
  input  logic                                  init_done_i,
  input  logic                                  q_full_i,
  output logic                                  push_o,
  output gmm_pkg::ctrl_t                        ctrl_o,
  output logic [GA_W-1:0]                       base_o,
  output logic [DW-1:0]                         data_o
);

  localparam int unsigned XW = gmm_pkg::ADDR_CALC_W;

  logic [5:0]                  chan6;
  logic                        past;
  logic [gmm_pkg::CHAN_W-1:0]  m_idx;
  logic                        mac_ok, coef_ok;
  logic [XW-1:0]               base_full, coef_full;

  assign chan6 = {1'b0, channel_i};
  assign past  = gmm_pkg::lfe_past(chan6, cfg_i.lfe_in_index);
  // channels above the LFE input move down one matrix input
  assign m_idx = channel_i - gmm_pkg::CHAN_W'(past);

  assign mac_ok = (channel_i < cfg_i.host_inputs)
               && !gmm_pkg::lfe_hit(chan6, cfg_i.lfe_in_index)
               && (7'(m_idx) < 7'(cfg_i.matrix_inputs))
               && (7'(m_idx) < 7'(MAX_MATRIX_IN));
  assign coef_ok = (7'(channel_i) < 7'(MAX_MATRIX_IN))
                && (7'(coef_out_index_i) < 7'(MAX_MATRIX_OUT));

  assign base_full = XW'(m_idx) * XW'(MAX_MATRIX_OUT);
  assign coef_full = XW'(channel_i) * XW'(MAX_MATRIX_OUT) + XW'(coef_out_index_i);

  always_comb begin
    ctrl_o.frame_end = 1'b0;
    if (mode_i) begin
      ctrl_o.op = coef_ok ? gmm_pkg::OP_COEF : gmm_pkg::OP_SKIP;
      base_o    = coef_full[GA_W-1:0];
      data_o    = DW'(gain_value_i);
    end else begin
      ctrl_o.op        = mac_ok ? gmm_pkg::OP_MAC : gmm_pkg::OP_SKIP;
      ctrl_o.frame_end = frame_end_i;
      base_o           = base_full[GA_W-1:0];
      data_o           = DW'(sample_in_i);
    end
  end

  assign in_stall_o = !init_done_i || q_full_i;
  // transactions that change nothing are dropped here
  assign push_o = in_valid_i && !in_stall_o
               && !(ctrl_o.op == gmm_pkg::OP_SKIP && !ctrl_o.frame_end);

endmodule

[src/gmm_back.sv]
`include "gain_matrix_mixer_with_lfe_defines.svh"

module gmm_back #(
  parameter int unsigned MAX_MATRIX_IN  = gmm_pkg::MAX_MATRIX_IN_DEF,
  parameter int unsigned MAX_MATRIX_OUT = gmm_pkg::MAX_MATRIX_OUT_DEF,
  parameter int unsigned MAX_HOST_OUT   = gmm_pkg::MAX_HOST_OUT_DEF,
  parameter int unsigned SAMPLE_BITS    = gmm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_BITS      = gmm_pkg::GAIN_BITS_DEF,
  localparam int unsigned GA_DEPTH = MAX_MATRIX_IN * MAX_MATRIX_OUT,
  localparam int unsigned GA_W     = (GA_DEPTH > 1) ? $clog2(GA_DEPTH) : 1,
  localparam int unsigned DW       = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gmm_pkg::cfg_t                     cfg_i,
  input  logic                              q_valid_i,
  input  gmm_pkg::ctrl_t                    q_ctrl_i,
  input  logic [GA_W-1:0]                   q_base_i,
  input  logic [DW-1:0]                     q_data_i,
  output logic                              q_pop_o,
  output logic                              init_done_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gmm_pkg::CHAN_W-1:0]        out_channel_o,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o,
  output logic                              last_of_frame_o
);

  localparam int unsigned AB        = gmm_pkg::ACC_BITS;
  localparam int unsigned AW        = (MAX_MATRIX_OUT > 1) ? $clog2(MAX_MATRIX_OUT) : 1;
  localparam int unsigned PW        = SAMPLE_BITS + GAIN_BITS;
  localparam int unsigned SUM_W     = ((PW > AB) ? PW : AB) + 1;
  localparam int unsigned RW        = AB + 1;
  localparam int unsigned OUT_SHIFT = GAIN_BITS - 4;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W - AB + 1){1'b0}}, {(AB - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN =
    {{(SUM_W - AB + 1){1'b1}}, {(AB - 1){1'b0}}};
  localparam logic signed [RW-1:0] SMP_MAX =
    {{(RW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [RW-1:0] SMP_MIN =
    {{(RW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (OUT_SHIFT - 1);

  gmm_pkg::state_e st_q, st_d;

  logic [GA_W-1:0]               init_addr_q;
  logic [GA_W-1:0]               base_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic                          fe_q;
  logic [AW-1:0]                 k_q;
  logic [5:0]                    ek_q;
  logic [AW-1:0]                 n_q;
  logic                          live_q;

  logic                          p1_valid_q, p2_valid_q;
  logic [AW-1:0]                 p1_k_q, p2_k_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [AB-1:0]          acc_cur_q;
  logic [MAX_MATRIX_OUT-1:0]     acc_vld_q;

  logic                          out_valid_q;
  logic [gmm_pkg::CHAN_W-1:0]    out_channel_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_last_q;

  // control from the sequencer
  logic                          gain_we, issue, acc_re, out_load, clr_vld;
  logic [GA_W-1:0]               gain_waddr;
  logic [GAIN_BITS-1:0]          gain_wdata;
  logic [AW-1:0]                 acc_raddr;

  logic [GAIN_BITS-1:0]          gain_rdata;
  logic [AB-1:0]                 acc_rdata;
  logic [GA_W-1:0]               gain_raddr;

  logic                          lfe_in_on, lfe_out_on, dims_ok;
  logic [6:0]                    kmax, nout, n7;
  logic                          k_last, emit_last, slot_free, slot_live;
  logic [AW-1:0]                 n_idx;

  logic signed [SUM_W-1:0]       sum;
  logic [AB-1:0]                 acc_wdata;
  logic signed [AB-1:0]          acc_emit;
  logic signed [RW-1:0]          rnd, shr;
  logic signed [SAMPLE_BITS-1:0] smp_sat;

  // ---------------------------------------------------------------- config view
  assign lfe_in_on  = !cfg_i.lfe_in_index[5];
  assign lfe_out_on = !cfg_i.lfe_out_index[5];
  assign dims_ok = (cfg_i.matrix_inputs != '0) && (cfg_i.matrix_outputs != '0)
                && (7'(cfg_i.matrix_inputs) <= 7'(MAX_MATRIX_IN))
                && (7'(cfg_i.matrix_outputs) <= 7'(MAX_MATRIX_OUT))
                && (7'(cfg_i.matrix_inputs) + 7'(lfe_in_on) == 7'(cfg_i.host_inputs))
                && (7'(cfg_i.matrix_outputs) + 7'(lfe_out_on) <= 7'(cfg_i.host_outputs));
  assign kmax = (7'(cfg_i.matrix_outputs) > 7'(MAX_MATRIX_OUT)) ?
                7'(MAX_MATRIX_OUT) : 7'(cfg_i.matrix_outputs);
  assign nout = (7'(cfg_i.host_outputs) > 7'(MAX_HOST_OUT)) ?
                7'(MAX_HOST_OUT) : 7'(cfg_i.host_outputs);
  assign k_last = (7'(k_q) + 7'd1 >= kmax);

  // emit slot mapping
  assign n7 = 7'(ek_q) - 7'(gmm_pkg::lfe_past(ek_q, cfg_i.lfe_out_index));
  assign n_idx = n7[AW-1:0];
  assign slot_live = dims_ok && !gmm_pkg::lfe_hit(ek_q, cfg_i.lfe_out_index)
                  && (n7 < 7'(cfg_i.matrix_outputs)) && (n7 < 7'(MAX_MATRIX_OUT));
  assign emit_last = (7'(ek_q) + 7'd1 == nout);
  assign slot_free = !out_valid_q || !out_stall_i;

  assign init_done_o = (st_q != gmm_pkg::ST_INIT);

  // ---------------------------------------------------------------- next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      gmm_pkg::ST_INIT: begin
        if (init_addr_q == GA_W'(GA_DEPTH - 1)) begin
          st_d = gmm_pkg::ST_IDLE;
        end
      end
      gmm_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          case (q_ctrl_i.op)
            gmm_pkg::OP_MAC: begin
              if (kmax != '0) begin
                st_d = gmm_pkg::ST_MAC;
              end else if (q_ctrl_i.frame_end) begin
                st_d = gmm_pkg::ST_EMIT_RD;
              end
            end
            gmm_pkg::OP_SKIP: begin
              if (q_ctrl_i.frame_end) begin
                st_d = gmm_pkg::ST_EMIT_RD;
              end
            end
            default: ;
          endcase
        end
      end
      gmm_pkg::ST_MAC: begin
        if (k_last) begin
          st_d = gmm_pkg::ST_DRAIN;
        end
      end
      gmm_pkg::ST_DRAIN: begin
        if (!p1_valid_q && !p2_valid_q) begin
          st_d = fe_q ? gmm_pkg::ST_EMIT_RD : gmm_pkg::ST_IDLE;
        end
      end
      gmm_pkg::ST_EMIT_RD: begin
        st_d = (nout == '0) ? gmm_pkg::ST_IDLE : gmm_pkg::ST_EMIT_OUT;
      end
      gmm_pkg::ST_EMIT_OUT: begin
        if (slot_free) begin
          st_d = emit_last ? gmm_pkg::ST_IDLE : gmm_pkg::ST_EMIT_RD;
        end
      end
      default: st_d = gmm_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    gain_we    = 1'b0;
    gain_waddr = init_addr_q;
    gain_wdata = '0;
    issue      = 1'b0;
    acc_re     = 1'b0;
    acc_raddr  = k_q;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    clr_vld    = 1'b0;
    unique case (st_q)
      gmm_pkg::ST_INIT: begin
        gain_we = 1'b1;
      end
      gmm_pkg::ST_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && q_ctrl_i.op == gmm_pkg::OP_COEF) begin
          gain_we    = 1'b1;
          gain_waddr = q_base_i;
          gain_wdata = q_data_i[GAIN_BITS-1:0];
        end
      end
      gmm_pkg::ST_MAC: begin
        issue  = 1'b1;
        acc_re = 1'b1;
      end
      gmm_pkg::ST_EMIT_RD: begin
        acc_re    = (nout != '0);
        acc_raddr = n_idx;
        clr_vld   = (nout == '0);
      end
      gmm_pkg::ST_EMIT_OUT: begin
        out_load = slot_free;
        clr_vld  = slot_free && emit_last;
      end
      default: ;
    endcase
  end

  assign gain_raddr = base_q + GA_W'(k_q);

  // ---------------------------------------------------------------- datapath
  assign sum = SUM_W'(acc_cur_q) + SUM_W'(prod_q);
  always_comb begin
    if (sum > ACC_MAX) begin
      acc_wdata = ACC_MAX[AB-1:0];
    end else if (sum < ACC_MIN) begin
      acc_wdata = ACC_MIN[AB-1:0];
    end else begin
      acc_wdata = sum[AB-1:0];
    end
  end

  // round half up, then clip to the sample range
  assign acc_emit = acc_vld_q[n_q] ? $signed(acc_rdata) : '0;
  assign rnd      = RW'(acc_emit) + HALF;
  assign shr      = rnd >>> OUT_SHIFT;
  always_comb begin
    if (shr > SMP_MAX) begin
      smp_sat = SMP_MAX[SAMPLE_BITS-1:0];
    end else if (shr < SMP_MIN) begin
      smp_sat = SMP_MIN[SAMPLE_BITS-1:0];
    end else begin
      smp_sat = shr[SAMPLE_BITS-1:0];
    end
  end

  gmm_ram #(
    .WIDTH (GAIN_BITS),
    .DEPTH (GA_DEPTH)
  ) u_gain_ram (
    .clk_i   (clk_i),
    .we_i    (gain_we),
    .waddr_i (gain_waddr),
    .wdata_i (gain_wdata),
    .re_i    (issue),
    .raddr_i (gain_raddr),
    .rdata_o (gain_rdata)
  );

  gmm_ram #(
    .WIDTH (AB),
    .DEPTH (MAX_MATRIX_OUT)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (p2_valid_q),
    .waddr_i (p2_k_q),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= gmm_pkg::ST_INIT;
      init_addr_q <= '0;
      k_q         <= '0;
      ek_q        <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      acc_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      p1_valid_q <= issue;
      p2_valid_q <= p1_valid_q;
      if (st_q == gmm_pkg::ST_INIT) begin
        init_addr_q <= init_addr_q + GA_W'(1);
      end
      if (q_pop_o) begin
        k_q  <= '0;
        ek_q <= '0;
      end else begin
        if (issue) begin
          k_q <= k_q + AW'(1);
        end
        if (out_load && !emit_last) begin
          ek_q <= ek_q + 6'd1;
        end
      end
      if (clr_vld) begin
        acc_vld_q <= '0;
      end else if (p2_valid_q) begin
        acc_vld_q[p2_k_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      base_q <= q_base_i;
      smp_q  <= $signed(q_data_i[SAMPLE_BITS-1:0]);
      fe_q   <= q_ctrl_i.frame_end;
    end
    p1_k_q    <= k_q;
    p2_k_q    <= p1_k_q;
    prod_q    <= smp_q * $signed(gain_rdata);
    acc_cur_q <= acc_vld_q[p1_k_q] ? $signed(acc_rdata) : '0;
    if (st_q == gmm_pkg::ST_EMIT_RD) begin
      n_q    <= n_idx;
      live_q <= slot_live;
    end
    if (out_load) begin
      out_channel_q <= ek_q[gmm_pkg::CHAN_W-1:0];
      out_sample_q  <= live_q ? smp_sat : '0;
      out_last_q    <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = out_channel_q;
  assign sample_out_o    = out_sample_q;
  assign last_of_frame_o = out_last_q;

  // ---------------------------------------------------------------- checks
  `GMM_ASSERT_ALWAYS(a_init_blocks_pop, !init_done_o |-> !q_pop_o, "transaction taken during RAM clear")
  `GMM_ASSERT(a_pop_pipe_empty, q_pop_o |-> !p1_valid_q && !p2_valid_q, "transaction taken with MAC in flight")
  `GMM_ASSERT(a_emit_no_mac, (st_q == gmm_pkg::ST_EMIT_RD || st_q == gmm_pkg::ST_EMIT_OUT) |-> !p1_valid_q && !p2_valid_q, "accumulator write during emission")
  `GMM_ASSERT(a_no_gain_write_in_mac, (st_q == gmm_pkg::ST_MAC) |-> !gain_we, "gain write while MAC reads")
  `GMM_ASSERT(a_frame_clears_acc, (out_load && emit_last) |=> (acc_vld_q == '0), "accumulators not cleared at frame end")

endmodule

[src/gain_matrix_mixer_with_lfe.sv]
// Gain-matrix audio mixer with LFE handling. Samples (Q1.23) arrive one host
// input channel per transaction and are multiplied by every gain of their
// matrix row (Q4.16) into 48-bit saturating accumulators; a transaction with
// mode set writes one gain instead. The host LFE input channel is skipped and
// the channels above it move down by one. A sample transaction with frame_end
// set produces one result per host output channel (at most MAX_HOST_OUT),
// rounded and saturated to the sample width; the LFE output slot is muted,
// later slots take the matrix output one below, surplus slots are zero, and
// the whole frame is silent when the configured dimensions disagree. A
// sample is handled by the single shared multiply-accumulate stepping
// through the matrix outputs one gain RAM read per cycle; a frame end
// then emits each host output channel by an accumulator RAM read and then
// the output register. A two-entry command queue lets the input side run
// ahead of this. After reset the gain RAM, MAX_MATRIX_IN * MAX_MATRIX_OUT
// entries (256 by default), is zeroed with in_stall_o held high;
// configuration writes are taken throughout and must only be made while
// the block is idle.
module gain_matrix_mixer_with_lfe #(
  parameter int unsigned MAX_MATRIX_IN  = gmm_pkg::MAX_MATRIX_IN_DEF,
  parameter int unsigned MAX_MATRIX_OUT = gmm_pkg::MAX_MATRIX_OUT_DEF,
  parameter int unsigned MAX_HOST_OUT   = gmm_pkg::MAX_HOST_OUT_DEF,
  parameter int unsigned SAMPLE_BITS    = gmm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_BITS      = gmm_pkg::GAIN_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [gmm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gmm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input transactions
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic [gmm_pkg::CHAN_W-1:0]         channel_i,
  input  logic [gmm_pkg::COEF_IDX_W-1:0]     coef_out_index_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_in_i,
  input  logic signed [GAIN_BITS-1:0]        gain_value_i,
  input  logic                               frame_end_i,
  // output transactions
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [gmm_pkg::CHAN_W-1:0]         out_channel_o,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o,
  output logic                               last_of_frame_o
);

  localparam int unsigned GA_DEPTH = MAX_MATRIX_IN * MAX_MATRIX_OUT;
  localparam int unsigned GA_W     = (GA_DEPTH > 1) ? $clog2(GA_DEPTH) : 1;
  localparam int unsigned DW       = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS;
  localparam int unsigned CW       = $bits(gmm_pkg::ctrl_t);
  localparam int unsigned QW       = CW + GA_W + DW;

  gmm_pkg::cfg_t   cfg_q, cfg_d;

  logic            push, q_full, q_valid, q_pop, init_done;
  gmm_pkg::ctrl_t  f_ctrl, q_ctrl;
  logic [GA_W-1:0] f_base, q_base;
  logic [DW-1:0]   f_data, q_data;
  logic [QW-1:0]   q_din, q_dout;

  // Register file. Unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (gmm_pkg::reg_idx_e'(cfg_index_i))
        gmm_pkg::REG_MATRIX_INPUTS:  cfg_d.matrix_inputs  = cfg_wdata_i[4:0];
        gmm_pkg::REG_MATRIX_OUTPUTS: cfg_d.matrix_outputs = cfg_wdata_i[4:0];
        gmm_pkg::REG_LFE_IN_INDEX:   cfg_d.lfe_in_index   = $signed(cfg_wdata_i);
        gmm_pkg::REG_LFE_OUT_INDEX:  cfg_d.lfe_out_index  = $signed(cfg_wdata_i);
        gmm_pkg::REG_HOST_INPUTS:    cfg_d.host_inputs    = cfg_wdata_i[4:0];
        gmm_pkg::REG_HOST_OUTPUTS:   cfg_d.host_outputs   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.matrix_inputs  <= '0;
      cfg_q.matrix_outputs <= '0;
      cfg_q.lfe_in_index   <= '1;  // no LFE
      cfg_q.lfe_out_index  <= '1;
      cfg_q.host_inputs    <= '0;
      cfg_q.host_outputs   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: takes transactions and turns them into commands.
  gmm_front #(
    .MAX_MATRIX_IN  (MAX_MATRIX_IN),
    .MAX_MATRIX_OUT (MAX_MATRIX_OUT),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_BITS      (GAIN_BITS)
  ) u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .channel_i        (channel_i),
    .coef_out_index_i (coef_out_index_i),
    .sample_in_i      (sample_in_i),
    .gain_value_i     (gain_value_i),
    .frame_end_i      (frame_end_i),
    .cfg_i            (cfg_q),
    .init_done_i      (init_done),
    .q_full_i         (q_full),
    .push_o           (push),
    .ctrl_o           (f_ctrl),
    .base_o           (f_base),
    .data_o           (f_data)
  );

  // Command queue between the two halves.
  assign q_din = {f_ctrl, f_base, f_data};

  gmm_queue #(
    .WIDTH (QW),
    .DEPTH (gmm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_dout)
  );

  assign q_ctrl = gmm_pkg::ctrl_t'(q_dout[QW-1 -: CW]);
  assign q_base = q_dout[GA_W+DW-1 -: GA_W];
  assign q_data = q_dout[DW-1:0];

  // Back end: gain RAM, MAC pipeline, accumulators and frame emission.
  gmm_back #(
    .MAX_MATRIX_IN  (MAX_MATRIX_IN),
    .MAX_MATRIX_OUT (MAX_MATRIX_OUT),
    .MAX_HOST_OUT   (MAX_HOST_OUT),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_BITS      (GAIN_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_ctrl_i        (q_ctrl),
    .q_base_i        (q_base),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .init_done_o     (init_done),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_channel_o   (out_channel_o),
    .sample_out_o    (sample_out_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
